FILE: rtl/i2cmbe_pkg.sv
// Package for the I2C master bit engine: item kinds, field widths and the
// item, result and configuration-write types and the status codes shared by the sequencer and the top level.
// No dependencies.
package i2cmbe_pkg;

    localparam int KIND_W   = 3;
    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int TICKS_W  = 8;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 16;

    localparam logic [KIND_W-1:0] KIND_START = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd4;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_ACK   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BUS_BUSY = 2'd2;

    localparam logic CFG_HALF_BIT  = 1'b0;
    localparam logic CFG_BUS_CHECK = 1'b1;

    localparam logic [TICKS_W-1:0] HALF_BIT_RESET  = 8'd1;
    localparam logic [TICKS_W-1:0] BUS_CHECK_RESET = 8'd10;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] byte_value;
        logic              read_direction;
        logic              send_ack;
        logic              sda_line;
        logic              scl_line;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   read_data;
        logic [STATUS_W-1:0] status;
        logic                done_res;
        logic                busy_res;
        logic                sda_drive;
        logic                scl_drive;
    } result_t;

    typedef struct packed {
        logic         wr_en;
        logic         index;
        logic [TICKS_W-1:0] data;
    } cfg_write_t;

endpackage

FILE: rtl/i2cmbe_seq.sv
// Sequencer of the I2C master bit engine: configuration registers, the phase
// machine and the line levels; phase and line levels are updated once per accepted transaction.
// Depends on i2cmbe_pkg.
module i2cmbe_seq
    import i2cmbe_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_write_t cfg,
    input  logic       accept,
    input  item_t      item,
    output result_t    result
);

    localparam int PH_W = 4;
    localparam logic [PH_W-1:0] PH_IDLE        = 4'd0;
    localparam logic [PH_W-1:0] PH_START_CHECK = 4'd1;
    localparam logic [PH_W-1:0] PH_START_HOLD  = 4'd2;
    localparam logic [PH_W-1:0] PH_TX_HIGH     = 4'd3;
    localparam logic [PH_W-1:0] PH_TX_LOW      = 4'd4;
    localparam logic [PH_W-1:0] PH_ACK_HIGH    = 4'd5;
    localparam logic [PH_W-1:0] PH_ACK_SAMPLE  = 4'd6;
    localparam logic [PH_W-1:0] PH_RX_HIGH     = 4'd7;
    localparam logic [PH_W-1:0] PH_RX_SAMPLE   = 4'd8;
    localparam logic [PH_W-1:0] PH_RXACK_HIGH  = 4'd9;
    localparam logic [PH_W-1:0] PH_RXACK_LOW   = 4'd10;
    localparam logic [PH_W-1:0] PH_STOP_HIGH   = 4'd11;
    localparam logic [PH_W-1:0] PH_STOP_REL    = 4'd12;
    localparam logic [PH_W-1:0] PH_STOP_END    = 4'd13;

    logic [TICKS_W-1:0]  half_bit_reg;
    logic [TICKS_W-1:0]  bus_check_reg;
    logic [PH_W-1:0]     phase_reg, phase_next;
    logic [3:0]          bit_count_reg, bit_count_next;
    logic [BYTE_W-1:0]   shift_reg, shift_next;
    logic [TICKS_W-1:0]  wait_reg, wait_next;
    logic                scl_reg, scl_next;
    logic                sda_reg, sda_next;
    logic                ack_choice_reg, ack_choice_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [BYTE_W-1:0]   received_reg, received_next;
    logic                done;
    logic [TICKS_W-1:0]  half_units;
    logic [TICKS_W-1:0]  check_units;
    logic [3:0]          bit_count_dec;

    assign half_units    = (half_bit_reg == '0) ? TICKS_W'(1) : half_bit_reg;
    assign check_units   = (bus_check_reg == '0) ? TICKS_W'(1) : bus_check_reg;
    assign bit_count_dec = bit_count_reg - 4'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        bit_count_next  = bit_count_reg;
        shift_next      = shift_reg;
        wait_next       = wait_reg;
        scl_next        = scl_reg;
        sda_next        = sda_reg;
        ack_choice_next = ack_choice_reg;
        status_next     = status_reg;
        received_next   = received_reg;
        done            = 1'b0;
        if (accept)
        begin
            if (item.kind == KIND_TICK)
            begin
                if (phase_reg != PH_IDLE)
                begin
                    if (wait_reg > TICKS_W'(1))
                    begin
                        wait_next = wait_reg - TICKS_W'(1);
                    end
                    else
                    begin
                        wait_next = '0;
                        unique case (phase_reg)
                            PH_START_CHECK:
                            begin
                                if (!item.sda_line || !item.scl_line)
                                begin
                                    status_next = STATUS_BUS_BUSY;
                                    phase_next  = PH_IDLE;
                                    done        = 1'b1;
                                end
                                else
                                begin
                                    sda_next   = 1'b0;
                                    wait_next  = half_units;
                                    phase_next = PH_START_HOLD;
                                end
                            end
                            PH_START_HOLD:
                            begin
                                scl_next       = 1'b0;
                                bit_count_next = 4'd8;
                                sda_next       = shift_reg[BYTE_W-1];
                                shift_next     = {shift_reg[BYTE_W-2:0], 1'b0};
                                wait_next      = half_units;
                                phase_next     = PH_TX_HIGH;
                            end
                            PH_TX_HIGH:
                            begin
                                scl_next   = 1'b1;
                                wait_next  = half_units;
                                phase_next = PH_TX_LOW;
                            end
                            PH_TX_LOW:
                            begin
                                scl_next       = 1'b0;
                                bit_count_next = bit_count_dec;
                                wait_next      = half_units;
                                if (bit_count_dec != 4'd0)
                                begin
                                    sda_next   = shift_reg[BYTE_W-1];
                                    shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                                    phase_next = PH_TX_HIGH;
                                end
                                else
                                begin
                                    sda_next   = 1'b1;
                                    phase_next = PH_ACK_HIGH;
                                end
                            end
                            PH_ACK_HIGH:
                            begin
                                scl_next   = 1'b1;
                                wait_next  = half_units;
                                phase_next = PH_ACK_SAMPLE;
                            end
                            PH_ACK_SAMPLE:
                            begin
                                scl_next    = 1'b0;
                                status_next = item.sda_line ? STATUS_NO_ACK : STATUS_OK;
                                phase_next  = PH_IDLE;
                                done        = 1'b1;
                            end
                            PH_RX_HIGH:
                            begin
                                scl_next   = 1'b1;
                                wait_next  = half_units;
                                phase_next = PH_RX_SAMPLE;
                            end
                            PH_RX_SAMPLE:
                            begin
                                shift_next     = {shift_reg[BYTE_W-2:0], item.sda_line};
                                scl_next       = 1'b0;
                                bit_count_next = bit_count_dec;
                                wait_next      = half_units;
                                if (bit_count_dec != 4'd0)
                                begin
                                    phase_next = PH_RX_HIGH;
                                end
                                else
                                begin
                                    sda_next   = !ack_choice_reg;
                                    phase_next = PH_RXACK_HIGH;
                                end
                            end
                            PH_RXACK_HIGH:
                            begin
                                scl_next   = 1'b1;
                                wait_next  = half_units;
                                phase_next = PH_RXACK_LOW;
                            end
                            PH_RXACK_LOW:
                            begin
                                scl_next      = 1'b0;
                                received_next = shift_reg;
                                status_next   = STATUS_OK;
                                phase_next    = PH_IDLE;
                                done          = 1'b1;
                            end
                            PH_STOP_HIGH:
                            begin
                                scl_next   = 1'b1;
                                wait_next  = half_units;
                                phase_next = PH_STOP_REL;
                            end
                            PH_STOP_REL:
                            begin
                                sda_next   = 1'b1;
                                wait_next  = half_units;
                                phase_next = PH_STOP_END;
                            end
                            PH_STOP_END:
                            begin
                                status_next = STATUS_OK;
                                phase_next  = PH_IDLE;
                                done        = 1'b1;
                            end
                            default:
                            begin
                                phase_next = PH_IDLE;
                            end
                        endcase
                    end
                end
            end
            else if (phase_reg == PH_IDLE)
            begin
                unique case (item.kind)
                    KIND_START:
                    begin
                        sda_next   = 1'b1;
                        scl_next   = 1'b1;
                        shift_next = {item.byte_value[BYTE_W-1:1], item.read_direction};
                        wait_next  = check_units;
                        phase_next = PH_START_CHECK;
                    end
                    KIND_WRITE:
                    begin
                        bit_count_next = 4'd8;
                        sda_next       = item.byte_value[BYTE_W-1];
                        shift_next     = {item.byte_value[BYTE_W-2:0], 1'b0};
                        wait_next      = half_units;
                        phase_next     = PH_TX_HIGH;
                    end
                    KIND_READ:
                    begin
                        sda_next        = 1'b1;
                        bit_count_next  = 4'd8;
                        shift_next      = '0;
                        ack_choice_next = item.send_ack;
                        wait_next       = half_units;
                        phase_next      = PH_RX_HIGH;
                    end
                    KIND_STOP:
                    begin
                        sda_next   = 1'b0;
                        wait_next  = half_units;
                        phase_next = PH_STOP_HIGH;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        result.scl_drive = scl_next;
        result.sda_drive = sda_next;
        result.busy_res  = (phase_next != PH_IDLE);
        result.done_res  = done;
        result.status    = status_next;
        result.read_data = received_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_bit_reg   <= HALF_BIT_RESET;
            bus_check_reg  <= BUS_CHECK_RESET;
            phase_reg      <= PH_IDLE;
            bit_count_reg  <= '0;
            shift_reg      <= '0;
            wait_reg       <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            ack_choice_reg <= 1'b0;
            status_reg     <= STATUS_OK;
            received_reg   <= '0;
        end
        else
        begin
            if (cfg.wr_en && cfg.index == CFG_HALF_BIT)
            begin
                half_bit_reg <= cfg.data;
            end
            if (cfg.wr_en && cfg.index == CFG_BUS_CHECK)
            begin
                bus_check_reg <= cfg.data;
            end
            phase_reg      <= phase_next;
            bit_count_reg  <= bit_count_next;
            shift_reg      <= shift_next;
            wait_reg       <= wait_next;
            scl_reg        <= scl_next;
            sda_reg        <= sda_next;
            ack_choice_reg <= ack_choice_next;
            status_reg     <= status_next;
            received_reg   <= received_next;
        end
    end

    // Any phase other than idle always has a delay pending.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_IDLE) |-> (wait_reg != '0))
        else $error("active phase without a pending delay");

    // The bit counter stays within one byte while bits are being moved.
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_TX_HIGH || phase_reg == PH_TX_LOW ||
         phase_reg == PH_RX_HIGH || phase_reg == PH_RX_SAMPLE)
        |-> (bit_count_reg != 4'd0 && bit_count_reg <= 4'd8))
        else $error("bit counter out of range during a byte");

    // Completion is reported only on a tick that leaves an active phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (accept && item.kind == KIND_TICK && phase_reg != PH_IDLE &&
                  phase_next == PH_IDLE))
        else $error("completion reported outside an active phase");

    // Without a transaction the sequencer holds its state.
    assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(phase_reg) && $stable(wait_reg) && $stable(scl_reg) &&
                     $stable(sda_reg)))
        else $error("sequencer state changed without a transaction");

endmodule

FILE: rtl/i2c_master_bit_engine.sv
// A result is captured in the output register in the cycle after its input transaction is accepted.
// Throughput: one transaction per cycle unless the output stalls; the sequencer updates its
// phase, counters and line levels in the same cycle that it accepts an item. A new item is taken
// while the output register is empty or its result is being taken; a waiting result holds off input.
// Reset: asynchronous, active low; lines released, engine idle, delays 1 and 10 ticks.
// Top level of the I2C master bit engine. Depends on i2cmbe_pkg and i2cmbe_seq.
module i2c_master_bit_engine
    import i2cmbe_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic                   cfg_index,
    input  logic [TICKS_W-1:0]     cfg_data,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // byte_value[7:0], read_direction[8], send_ack[9], sda_line[10], scl_line[11]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    // kind[2:0]
    input  logic [KIND_W-1:0]      s_tuser,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // scl_drive[0], sda_drive[1], busy_res[2], done_res[3], status[5:4], read_data[13:6]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    cfg_write_t cfg;
    item_t      item;
    result_t    result;
    logic       accept;
    logic       out_valid_reg;
    result_t    out_reg;

    assign cfg.wr_en = cfg_wr_en;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign item.kind           = s_tuser;
    assign item.byte_value     = s_tdata[7:0];
    assign item.read_direction = s_tdata[8];
    assign item.send_ack       = s_tdata[9];
    assign item.sda_line       = s_tdata[10];
    assign item.scl_line       = s_tdata[11];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    i2cmbe_seq u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .accept (accept),
        .item   (item),
        .result (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_reg};

endmodule
